>>> rtl/gcfp_pkg.sv
// shared constants, result type and codes for the generator command frame parser
package gcfp_pkg;

  localparam int ACCUM_MAG_BITS_DEF = 20;

  // ascii codes
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_F     = 8'h46;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_W     = 8'h57;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MAX     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_MIN     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_MAX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_AMP_MIN      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_LIMIT = 3'd4;

  // reset values
  localparam logic [15:0] FREQ_MAX_RST     = 16'd2000;
  localparam logic [15:0] FREQ_MIN_RST     = 16'd20;
  localparam logic [15:0] AMP_MAX_RST      = 16'd10000;
  localparam logic [15:0] AMP_MIN_RST      = 16'd100;
  localparam logic [14:0] OFFSET_LIMIT_RST = 15'd5000;
  localparam logic [15:0] STORED_FREQ_RST  = 16'd20;
  localparam logic [15:0] STORED_AMP_RST   = 16'd100;
  localparam logic [15:0] STORED_OFS_RST   = 16'd0;

  // clamp status codes
  localparam logic [1:0] ST_IN_RANGE = 2'd0;
  localparam logic [1:0] ST_HIGH     = 2'd1;
  localparam logic [1:0] ST_LOW      = 2'd2;

  // waveform codes
  localparam logic [1:0] WF_SINE     = 2'd0;
  localparam logic [1:0] WF_TRIANGLE = 2'd1;
  localparam logic [1:0] WF_SAWTOOTH = 2'd2;
  localparam logic [1:0] WF_SQUARE   = 2'd3;

  typedef struct packed {
    logic        frame_valid;
    logic [1:0]  waveform;
    logic [15:0] frequency;
    logic [15:0] amplitude;
    logic [15:0] offset;
    logic        save_request;
    logic        type_unknown;
    logic [1:0]  freq_status;
    logic [1:0]  amp_status;
    logic [1:0]  offset_status;
  } res_t;

endpackage

>>> rtl/gcfp_queue.sv
// two-entry register queue between pipeline parts
module gcfp_queue #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr_en && !rd_en) begin
        count <= count + 2'd1;
      end else if (rd_en && !wr_en) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count != 2'd3)
    else $error("queue count out of range");
  a_write_fills: assert property (@(posedge clk) disable iff (rst)
    wr_en && !rd_en |=> !empty)
    else $error("queue empty after lone write");
  a_read_drains: assert property (@(posedge clk) disable iff (rst)
    rd_en && !wr_en && count == 2'd1 |=> empty)
    else $error("queue not empty after last read");

endmodule

>>> rtl/gcfp_front.sv
// front part: byte parser that builds one frame record per '#'
module gcfp_front import gcfp_pkg::*; #(
  parameter int MAG_BITS = ACCUM_MAG_BITS_DEF,
  parameter int REC_W    = 3 * (MAG_BITS + 1) + 10
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [7:0]       rx_byte,
  input  logic             rec_full,
  output logic             rec_push,
  output logic [REC_W-1:0] rec_data
);

  typedef enum logic [2:0] {FLD_NONE, FLD_S, FLD_F, FLD_A, FLD_O, FLD_W} field_t;
  typedef enum logic [1:0] {PH_LEAD, PH_DIGITS, PH_DONE} phase_t;

  logic                first, first_next;
  logic                start_ok, start_ok_next;
  logic                s_seen, s_seen_next;
  field_t              open_fld, open_fld_next;
  logic                skip, skip_next;
  phase_t              phase, phase_next;
  logic                neg, neg_next;
  logic [MAG_BITS-1:0] fmag, fmag_next;
  logic [MAG_BITS-1:0] amag, amag_next;
  logic [MAG_BITS-1:0] omag, omag_next;
  logic                fneg, fneg_next;
  logic                aneg, aneg_next;
  logic                oneg, oneg_next;
  logic                save, save_next;
  logic [7:0]          type_letter, type_letter_next;
  logic                accept;

  assign accept = push && !rec_full;

  function automatic logic is_space(input logic [7:0] b);
    return (b == CH_SPACE) || (b >= CH_TAB && b <= CH_CR);
  endfunction

  always_comb begin
    logic [MAG_BITS-1:0] mag_sel;
    logic [MAG_BITS+3:0] mag_ext;
    logic [MAG_BITS-1:0] mag_new;
    logic                run_digits;
    logic                is_digit;
    mag_sel    = '0;
    mag_ext    = '0;
    mag_new    = '0;
    run_digits = 1'b0;
    is_digit   = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);

    first_next       = first;
    start_ok_next    = start_ok;
    s_seen_next      = s_seen;
    open_fld_next    = open_fld;
    skip_next        = skip;
    phase_next       = phase;
    neg_next         = neg;
    fmag_next        = fmag;
    amag_next        = amag;
    omag_next        = omag;
    fneg_next        = fneg;
    aneg_next        = aneg;
    oneg_next        = oneg;
    save_next        = save;
    type_letter_next = type_letter;
    rec_push         = 1'b0;

    // first byte of a frame starts from a clean slate
    if (first) begin
      start_ok_next    = (rx_byte == CH_BANG);
      s_seen_next      = 1'b0;
      open_fld_next    = FLD_NONE;
      skip_next        = 1'b0;
      phase_next       = PH_LEAD;
      neg_next         = 1'b0;
      fmag_next        = '0;
      amag_next        = '0;
      omag_next        = '0;
      fneg_next        = 1'b0;
      aneg_next        = 1'b0;
      oneg_next        = 1'b0;
      save_next        = 1'b0;
      type_letter_next = '0;
    end

    if (accept) begin
      if (rx_byte == CH_HASH) begin
        rec_push   = 1'b1;
        first_next = 1'b1;
      end else begin
        first_next = 1'b0;
        if ((rx_byte == CH_S && !s_seen_next) || rx_byte == CH_F || rx_byte == CH_A ||
            rx_byte == CH_O || rx_byte == CH_W) begin
          skip_next  = 1'b1;
          phase_next = PH_LEAD;
          neg_next   = 1'b0;
          unique case (rx_byte)
            CH_S: begin
              s_seen_next      = 1'b1;
              open_fld_next    = FLD_S;
              type_letter_next = '0;
            end
            CH_F: begin
              open_fld_next = FLD_F;
              fmag_next     = '0;
              fneg_next     = 1'b0;
            end
            CH_A: begin
              open_fld_next = FLD_A;
              amag_next     = '0;
              aneg_next     = 1'b0;
            end
            CH_O: begin
              open_fld_next = FLD_O;
              omag_next     = '0;
              oneg_next     = 1'b0;
            end
            default: begin
              open_fld_next = FLD_W;
              save_next     = 1'b0;
            end
          endcase
        end else if (open_fld_next == FLD_NONE) begin
          skip_next = skip_next;
        end else if (skip_next) begin
          skip_next = 1'b0;
        end else if (open_fld_next == FLD_S) begin
          type_letter_next = rx_byte;
          open_fld_next    = FLD_NONE;
        end else begin
          if (phase_next == PH_LEAD) begin
            if (!is_space(rx_byte)) begin
              if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
                neg_next   = (rx_byte == CH_MINUS);
                phase_next = PH_DIGITS;
              end else begin
                phase_next = PH_DIGITS;
                run_digits = 1'b1;
              end
            end
          end else if (phase_next == PH_DIGITS) begin
            run_digits = 1'b1;
          end
          if (run_digits) begin
            if (is_digit) begin
              unique case (open_fld_next)
                FLD_F:   mag_sel = fmag_next;
                FLD_A:   mag_sel = amag_next;
                FLD_O:   mag_sel = omag_next;
                default: mag_sel = '0;
              endcase
              // times ten plus digit, saturating
              mag_ext = {1'b0, mag_sel, 3'b000} + {3'b000, mag_sel, 1'b0}
                      + {{MAG_BITS{1'b0}}, rx_byte[3:0]};
              mag_new = (mag_ext[MAG_BITS+3:MAG_BITS] != 4'd0) ? '1 : mag_ext[MAG_BITS-1:0];
              unique case (open_fld_next)
                FLD_F: begin
                  fmag_next = mag_new;
                  fneg_next = neg_next;
                end
                FLD_A: begin
                  amag_next = mag_new;
                  aneg_next = neg_next;
                end
                FLD_O: begin
                  omag_next = mag_new;
                  oneg_next = neg_next;
                end
                default: begin
                  if (rx_byte[3:0] != 4'd0) begin
                    save_next = 1'b1;
                  end
                end
              endcase
            end else begin
              phase_next    = PH_DONE;
              open_fld_next = FLD_NONE;
            end
          end
        end
      end
    end
  end

  assign rec_data = {start_ok_next, type_letter_next, save_next,
                     fneg_next, fmag_next, aneg_next, amag_next, oneg_next, omag_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      first       <= 1'b1;
      start_ok    <= 1'b0;
      s_seen      <= 1'b0;
      open_fld    <= FLD_NONE;
      skip        <= 1'b0;
      phase       <= PH_LEAD;
      neg         <= 1'b0;
      save        <= 1'b0;
      type_letter <= '0;
    end else begin
      first       <= first_next;
      start_ok    <= start_ok_next;
      s_seen      <= s_seen_next;
      open_fld    <= open_fld_next;
      skip        <= skip_next;
      phase       <= phase_next;
      neg         <= neg_next;
      save        <= save_next;
      type_letter <= type_letter_next;
    end
  end

  always_ff @(posedge clk) begin
    fmag <= fmag_next;
    amag <= amag_next;
    omag <= omag_next;
    fneg <= fneg_next;
    aneg <= aneg_next;
    oneg <= oneg_next;
  end

endmodule

>>> rtl/gcfp_back.sv
// back part: limit registers, clamping and stored generator settings
module gcfp_back import gcfp_pkg::*; #(
  parameter int MAG_BITS = ACCUM_MAG_BITS_DEF,
  parameter int REC_W    = 3 * (MAG_BITS + 1) + 10
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  input  logic                 rec_empty,
  input  logic [REC_W-1:0]     rec_data,
  output logic                 rec_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output res_t                 res_data
);

  localparam int VW = MAG_BITS + 1;

  logic [15:0] freq_max, freq_min, amp_max, amp_min;
  logic [14:0] offset_limit;
  logic [1:0]  stored_waveform, stored_waveform_next;
  logic [15:0] stored_frequency, stored_frequency_next;
  logic [15:0] stored_amplitude, stored_amplitude_next;
  logic [15:0] stored_offset, stored_offset_next;

  logic                r_start_ok;
  logic [7:0]          r_type;
  logic                r_save;
  logic                r_fneg, r_aneg, r_oneg;
  logic [MAG_BITS-1:0] r_fmag, r_amag, r_omag;

  assign {r_start_ok, r_type, r_save, r_fneg, r_fmag, r_aneg, r_amag, r_oneg, r_omag} = rec_data;

  assign rec_pop  = !rec_empty && !res_full;
  assign res_push = rec_pop;

  function automatic logic signed [VW-1:0] to_signed(input logic neg,
                                                     input logic [MAG_BITS-1:0] mag);
    logic signed [VW-1:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  // returns {status, clamped value}
  function automatic logic [17:0] clamp(input logic signed [VW-1:0] v,
                                        input logic signed [VW-1:0] lo,
                                        input logic signed [VW-1:0] hi);
    logic [17:0] r;
    if (v > hi) begin
      r = {ST_HIGH, hi[15:0]};
    end else if (v < lo) begin
      r = {ST_LOW, lo[15:0]};
    end else begin
      r = {ST_IN_RANGE, v[15:0]};
    end
    return r;
  endfunction

  always_comb begin
    logic signed [VW-1:0] ofs_hi;
    logic [17:0]          fc, ac, oc;
    logic                 unknown;
    ofs_hi  = $signed({{(VW-15){1'b0}}, offset_limit});
    fc      = clamp(to_signed(r_fneg, r_fmag),
                    $signed({{(VW-16){1'b0}}, freq_min}),
                    $signed({{(VW-16){1'b0}}, freq_max}));
    ac      = clamp(to_signed(r_aneg, r_amag),
                    $signed({{(VW-16){1'b0}}, amp_min}),
                    $signed({{(VW-16){1'b0}}, amp_max}));
    oc      = clamp(to_signed(r_oneg, r_omag), -ofs_hi, ofs_hi);
    unknown = 1'b0;

    stored_waveform_next  = stored_waveform;
    stored_frequency_next = stored_frequency;
    stored_amplitude_next = stored_amplitude;
    stored_offset_next    = stored_offset;
    if (r_start_ok) begin
      unique case (r_type)
        CH_S:    stored_waveform_next = WF_SINE;
        CH_T:    stored_waveform_next = WF_TRIANGLE;
        CH_D:    stored_waveform_next = WF_SAWTOOTH;
        CH_C:    stored_waveform_next = WF_SQUARE;
        default: unknown = 1'b1;
      endcase
      stored_frequency_next = fc[15:0];
      stored_amplitude_next = ac[15:0];
      stored_offset_next    = oc[15:0];
    end

    res_data.frame_valid   = r_start_ok;
    res_data.waveform      = stored_waveform_next;
    res_data.frequency     = stored_frequency_next;
    res_data.amplitude     = stored_amplitude_next;
    res_data.offset        = stored_offset_next;
    res_data.save_request  = r_start_ok && r_save;
    res_data.type_unknown  = unknown;
    res_data.freq_status   = r_start_ok ? fc[17:16] : ST_IN_RANGE;
    res_data.amp_status    = r_start_ok ? ac[17:16] : ST_IN_RANGE;
    res_data.offset_status = r_start_ok ? oc[17:16] : ST_IN_RANGE;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      freq_max         <= FREQ_MAX_RST;
      freq_min         <= FREQ_MIN_RST;
      amp_max          <= AMP_MAX_RST;
      amp_min          <= AMP_MIN_RST;
      offset_limit     <= OFFSET_LIMIT_RST;
      stored_waveform  <= WF_SINE;
      stored_frequency <= STORED_FREQ_RST;
      stored_amplitude <= STORED_AMP_RST;
      stored_offset    <= STORED_OFS_RST;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_FREQ_MAX:     freq_max     <= cfg_data;
          CFG_FREQ_MIN:     freq_min     <= cfg_data;
          CFG_AMP_MAX:      amp_max      <= cfg_data;
          CFG_AMP_MIN:      amp_min      <= cfg_data;
          CFG_OFFSET_LIMIT: offset_limit <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (rec_pop) begin
        stored_waveform  <= stored_waveform_next;
        stored_frequency <= stored_frequency_next;
        stored_amplitude <= stored_amplitude_next;
        stored_offset    <= stored_offset_next;
      end
    end
  end

  a_invalid_keeps: assert property (@(posedge clk) disable iff (rst)
    rec_pop && !r_start_ok |=> $stable(stored_frequency) && $stable(stored_amplitude)
                               && $stable(stored_offset) && $stable(stored_waveform))
    else $error("invalid frame changed stored settings");
  a_freq_high: assert property (@(posedge clk) disable iff (rst)
    rec_pop && r_start_ok && res_data.freq_status == ST_HIGH
    |=> stored_frequency == $past(freq_max))
    else $error("frequency clamped high but not at maximum");
  a_offset_bound: assert property (@(posedge clk) disable iff (rst)
    rec_pop && r_start_ok |=>
      $signed(stored_offset) <= $signed({1'b0, $past(offset_limit)}) &&
      $signed(stored_offset) >= -$signed({1'b0, $past(offset_limit)}))
    else $error("stored offset outside limit");

endmodule

>>> rtl/generator_command_frame_parser_unit.sv
// top level of the generator command frame parser
// throughput: one byte per clock cycle while full is low, a '#' beat included
// the result of a frame is registered in both queues before it reaches the result ports
// (front parser -> two-entry record queue -> clamp stage -> two-entry result queue)
// full rises only when the record queue holds two frames not yet clamped
// reset (synchronous): queues emptied, parser awaits a frame start, limits and settings restored
module generator_command_frame_parser_unit import gcfp_pkg::*; #(
  parameter int ACCUM_MAG_BITS = ACCUM_MAG_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           rx_byte,
  output logic                 empty,
  input  logic                 pop,
  output logic                 frame_valid,
  output logic [1:0]           waveform,
  output logic [15:0]          frequency,
  output logic [15:0]          amplitude,
  output logic signed [15:0]   offset,
  output logic                 save_request,
  output logic                 type_unknown,
  output logic [1:0]           freq_status,
  output logic [1:0]           amp_status,
  output logic [1:0]           offset_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data
);

  localparam int REC_W = 3 * (ACCUM_MAG_BITS + 1) + 10;

  logic             rec_push, rec_full, rec_pop, rec_empty;
  logic [REC_W-1:0] rec_wr, rec_rd;
  logic             res_push, res_full, res_pop;
  res_t             res_wr, res_rd;

  assign cfg_ready = 1'b1;
  assign res_pop   = pop && !empty;
  assign full      = rec_full;

  gcfp_front #(.MAG_BITS(ACCUM_MAG_BITS), .REC_W(REC_W)) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .rx_byte  (rx_byte),
    .rec_full (rec_full),
    .rec_push (rec_push),
    .rec_data (rec_wr)
  );

  gcfp_queue #(.WIDTH(REC_W)) u_rec_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (rec_push),
    .wr_data (rec_wr),
    .full    (rec_full),
    .rd_en   (rec_pop),
    .rd_data (rec_rd),
    .empty   (rec_empty)
  );

  gcfp_back #(.MAG_BITS(ACCUM_MAG_BITS), .REC_W(REC_W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rec_empty (rec_empty),
    .rec_data  (rec_rd),
    .rec_pop   (rec_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_wr)
  );

  gcfp_queue #(.WIDTH($bits(res_t))) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .rd_en   (res_pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign frame_valid   = res_rd.frame_valid;
  assign waveform      = res_rd.waveform;
  assign frequency     = res_rd.frequency;
  assign amplitude     = res_rd.amplitude;
  assign offset        = $signed(res_rd.offset);
  assign save_request  = res_rd.save_request;
  assign type_unknown  = res_rd.type_unknown;
  assign freq_status   = res_rd.freq_status;
  assign amp_status    = res_rd.amp_status;
  assign offset_status = res_rd.offset_status;

endmodule
